// ----- hdl/mi3_pkg.sv -----
// Shared constants and index tables for the 3x3 matrix inverse unit.
// No dependencies; used by matrix_inverse_3x3_unit and mi3_div.
package mi3_pkg;

  localparam int DATA_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF  = 16;

  typedef logic [3:0] idx_t;

  // Store indexes of the 2x2 cofactor operands, per adjugate entry:
  // entry = A*B - C*D.
  localparam idx_t COF_A [9] = '{4'd4, 4'd7, 4'd1, 4'd5, 4'd8, 4'd2, 4'd3, 4'd6, 4'd0};
  localparam idx_t COF_B [9] = '{4'd8, 4'd2, 4'd5, 4'd6, 4'd0, 4'd3, 4'd7, 4'd1, 4'd4};
  localparam idx_t COF_C [9] = '{4'd5, 4'd8, 4'd2, 4'd3, 4'd6, 4'd0, 4'd4, 4'd7, 4'd1};
  localparam idx_t COF_D [9] = '{4'd7, 4'd1, 4'd4, 4'd8, 4'd2, 4'd5, 4'd6, 4'd0, 4'd3};

  // Adjugate entries that pair with the first matrix row in the determinant.
  localparam idx_t DET_ADJ [3] = '{4'd0, 4'd3, 4'd6};

endpackage

// ----- hdl/mi3_div.sv -----
// Restoring divider with round-half-away and saturation for the inverse unit.
// Depends on mi3_pkg (loaded first); instantiated by matrix_inverse_3x3_unit.
module mi3_div #(
  parameter int DATA_WIDTH = mi3_pkg::DATA_WIDTH_DEF,
  parameter int NUM_WIDTH  = 2 * mi3_pkg::DATA_WIDTH_DEF + 1 + 2 * mi3_pkg::FRAC_BITS_DEF,
  parameter int DEN_WIDTH  = 3 * mi3_pkg::DATA_WIDTH_DEF + 3
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic                  neg_i,
  input  logic [NUM_WIDTH-1:0]  num_i,
  input  logic [DEN_WIDTH-1:0]  den_i,
  output logic                  done_o,
  output logic [DATA_WIDTH-1:0] quo_o,
  output logic                  sat_o
);

  localparam int W  = DATA_WIDTH;
  localparam int RW = (DEN_WIDTH + 1 > NUM_WIDTH - W) ? DEN_WIDTH + 1 : NUM_WIDTH - W;
  localparam int CW = $clog2(W + 1) + 1;

  logic          run_q, fin_q, done_q;
  logic [CW-1:0] cnt_q;
  logic [RW-1:0] r_q, r_init, r_sh, r_d, den_ext;
  logic [W:0]    low_q, q_q, qr, half;
  logic [W+1:0]  qsum;
  logic          neg_q, presat_q, ge, neg_eff, over;
  logic [W-1:0]  quo_q, qlo, qneg, val;
  logic          sat_q;

  assign den_ext = RW'(den_i);
  assign r_init  = RW'(num_i >> W);
  assign r_sh    = {r_q[RW-2:0], low_q[W]};
  assign ge      = r_sh >= den_ext;
  assign r_d     = ge ? r_sh - den_ext : r_sh;

  assign qsum    = {1'b0, q_q} + (W+2)'(1);
  assign qr      = qsum[W+1:1];
  assign half    = (W+1)'(1) << (W - 1);
  assign neg_eff = neg_q & (presat_q | (qr != '0));
  assign over    = presat_q | (neg_eff ? (qr > half) : (qr >= half));
  assign qlo     = qr[W-1:0];
  assign qneg    = '0 - qlo;
  always_comb begin
    if (over) begin
      val = neg_eff ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
    end else begin
      val = neg_eff ? qneg : qlo;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      fin_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      fin_q  <= 1'b0;
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= CW'(W);
      end else if (run_q) begin
        if (cnt_q == '0) begin
          run_q <= 1'b0;
          fin_q <= 1'b1;
        end else begin
          cnt_q <= cnt_q - 1'b1;
        end
      end
      if (fin_q) begin
        done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      r_q      <= r_init;
      low_q    <= {num_i[W-1:0], 1'b0};
      q_q      <= '0;
      neg_q    <= neg_i;
      presat_q <= r_init >= den_ext;
    end else if (run_q) begin
      r_q   <= r_d;
      low_q <= {low_q[W-1:0], 1'b0};
      q_q   <= {q_q[W-1:0], ge};
    end
    if (fin_q) begin
      quo_q <= val;
      sat_q <= over;
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;
  assign sat_o  = sat_q;

endmodule

// ----- hdl/matrix_inverse_3x3_unit.sv -----
// 3x3 matrix inverse by adjugate over determinant, signed fixed point; uses mi3_pkg, mi3_div.
// The cofactor products and then the determinant products run on one shared multiplier after
// the ninth element; each result then comes from the bit-serial divider, or is zero if singular.
// A new matrix is accepted only after all nine results are out; results cannot stall.
// Reset clears the sequencer and load count; the element store is not cleared.
module matrix_inverse_3x3_unit #(
  parameter int DATA_WIDTH = mi3_pkg::DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = mi3_pkg::FRAC_BITS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start,
  output logic                         busy,
  input  logic signed [DATA_WIDTH-1:0] element_in_i,
  output logic                         out_strobe_o,
  output logic signed [DATA_WIDTH-1:0] element_out_o,
  output logic                         last_element_o,
  output logic                         singular_o,
  output logic                         saturated_o
);

  localparam int W  = DATA_WIDTH;
  localparam int OW = W + 1;
  localparam int PW = 2 * W + 2;
  localparam int AW = 2 * W + 1;
  localparam int SW = 3 * W + 3;
  localparam int NW = AW + 2 * FRAC_BITS;

  localparam logic [2:0] ST_LOAD = 3'd0;
  localparam logic [2:0] ST_COF  = 3'd1;
  localparam logic [2:0] ST_DET  = 3'd2;
  localparam logic [2:0] ST_DIV  = 3'd3;

  logic [2:0]           state_q;
  logic [3:0]           load_cnt_q, k_q;
  logic                 t_q;
  logic [1:0]           sub_q;
  logic [W-1:0]         store_q [9];
  logic [AW-1:0]        adj_q [9];
  logic signed [OW-1:0] op_a_q, mul_b;
  logic signed [PW-1:0] prod_q, prod_d;
  logic signed [SW-1:0] acc_q, prod_ext, prod_sh;
  logic                 strobe_q, last_q, sing_q, sat_q;
  logic [W-1:0]         out_q;

  mi3_pkg::idx_t        rd_idx, adj_idx;
  logic [W-1:0]         store_rd;
  logic [AW-1:0]        adj_rd, adj_mag;
  logic [SW-1:0]        den;
  logic [NW-1:0]        num;
  logic                 accept, singular, div_start, div_done, div_sat, div_neg;
  logic [W-1:0]         div_quo;

  assign accept   = start && (state_q == ST_LOAD);
  assign singular = (acc_q == '0);

  always_comb begin
    rd_idx  = k_q;
    adj_idx = k_q;
    unique case (state_q)
      ST_COF: begin
        if (sub_q == 2'd0) begin
          rd_idx = t_q ? mi3_pkg::COF_C[k_q] : mi3_pkg::COF_A[k_q];
        end else begin
          rd_idx = t_q ? mi3_pkg::COF_D[k_q] : mi3_pkg::COF_B[k_q];
        end
      end
      ST_DET: begin
        adj_idx = mi3_pkg::DET_ADJ[k_q[1:0]];
      end
      default: begin
        rd_idx  = k_q;
        adj_idx = k_q;
      end
    endcase
  end

  assign store_rd = store_q[rd_idx];
  assign adj_rd   = adj_q[adj_idx];
  assign mul_b    = {store_rd[W-1], store_rd};
  assign prod_d   = op_a_q * mul_b;
  assign prod_ext = {{(SW-PW){prod_q[PW-1]}}, prod_q};
  assign prod_sh  = t_q ? (prod_ext <<< W) : prod_ext;

  assign adj_mag   = adj_rd[AW-1] ? ('0 - adj_rd) : adj_rd;
  assign num       = NW'(adj_mag) << (2 * FRAC_BITS);
  assign den       = acc_q[SW-1] ? ('0 - acc_q) : acc_q;
  assign div_neg   = adj_rd[AW-1] ^ acc_q[SW-1];
  assign div_start = (state_q == ST_DIV) && !singular && (sub_q == 2'd0);

  mi3_div #(
    .DATA_WIDTH (W),
    .NUM_WIDTH  (NW),
    .DEN_WIDTH  (SW)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .neg_i   (div_neg),
    .num_i   (num),
    .den_i   (den),
    .done_o  (div_done),
    .quo_o   (div_quo),
    .sat_o   (div_sat)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_LOAD;
      load_cnt_q <= '0;
      k_q        <= '0;
      t_q        <= 1'b0;
      sub_q      <= '0;
      strobe_q   <= 1'b0;
    end else begin
      strobe_q <= 1'b0;
      unique case (state_q)
        ST_LOAD: begin
          if (start) begin
            if (load_cnt_q == 4'd8) begin
              load_cnt_q <= '0;
              state_q    <= ST_COF;
              k_q        <= '0;
              t_q        <= 1'b0;
              sub_q      <= '0;
            end else begin
              load_cnt_q <= load_cnt_q + 1'b1;
            end
          end
        end
        ST_COF: begin
          unique case (sub_q)
            2'd0: sub_q <= 2'd1;
            2'd1: sub_q <= 2'd2;
            2'd2: begin
              if (!t_q) begin
                t_q   <= 1'b1;
                sub_q <= 2'd0;
              end else begin
                t_q   <= 1'b0;
                sub_q <= 2'd3;
              end
            end
            default: begin
              sub_q <= 2'd0;
              if (k_q == 4'd8) begin
                k_q     <= '0;
                state_q <= ST_DET;
              end else begin
                k_q <= k_q + 1'b1;
              end
            end
          endcase
        end
        ST_DET: begin
          if (sub_q == 2'd2) begin
            sub_q <= 2'd0;
            if (!t_q) begin
              t_q <= 1'b1;
            end else begin
              t_q <= 1'b0;
              if (k_q == 4'd2) begin
                k_q     <= '0;
                state_q <= ST_DIV;
              end else begin
                k_q <= k_q + 1'b1;
              end
            end
          end else begin
            sub_q <= sub_q + 1'b1;
          end
        end
        default: begin
          if (singular || (sub_q == 2'd1 && div_done)) begin
            strobe_q <= 1'b1;
            sub_q    <= 2'd0;
            if (k_q == 4'd8) begin
              k_q     <= '0;
              state_q <= ST_LOAD;
            end else begin
              k_q <= k_q + 1'b1;
            end
          end else if (sub_q == 2'd0) begin
            sub_q <= 2'd1;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      store_q[load_cnt_q] <= element_in_i;
    end
    unique case (state_q)
      ST_COF: begin
        unique case (sub_q)
          2'd0: op_a_q <= {store_rd[W-1], store_rd};
          2'd1: prod_q <= prod_d;
          2'd2: acc_q  <= t_q ? (acc_q - prod_ext) : prod_ext;
          default: begin
            adj_q[k_q] <= acc_q[AW-1:0];
            acc_q      <= '0;
          end
        endcase
      end
      ST_DET: begin
        unique case (sub_q)
          2'd0: op_a_q <= t_q ? $signed(adj_rd[AW-1:W]) : $signed({1'b0, adj_rd[W-1:0]});
          2'd1: prod_q <= prod_d;
          default: acc_q <= acc_q + prod_sh;
        endcase
      end
      ST_DIV: begin
        if (singular) begin
          out_q  <= '0;
          sat_q  <= 1'b0;
          sing_q <= 1'b1;
          last_q <= (k_q == 4'd8);
        end else if (sub_q == 2'd1 && div_done) begin
          out_q  <= div_quo;
          sat_q  <= div_sat;
          sing_q <= 1'b0;
          last_q <= (k_q == 4'd8);
        end
      end
      default: begin
      end
    endcase
  end

  assign busy           = (state_q != ST_LOAD);
  assign out_strobe_o   = strobe_q;
  assign element_out_o  = out_q;
  assign last_element_o = last_q;
  assign singular_o     = sing_q;
  assign saturated_o    = sat_q;

endmodule

// ----- verif/tb.sv -----
// Self-checking testbench for matrix_inverse_3x3_unit: sends 3x3 Q16.16 matrices
// and compares every inverse element with an exact adjugate/determinant predictor.
// Depends on mi3_pkg and matrix_inverse_3x3_unit.
module tb;

  localparam int DW = mi3_pkg::DATA_WIDTH_DEF;
  localparam int FB = mi3_pkg::FRAC_BITS_DEF;

  typedef struct {
    logic signed [DW-1:0] elem;
    logic                 last;
    logic                 sing;
    logic                 sat;
  } inv_elem_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 start = 1'b0;
  logic                 busy;
  logic signed [DW-1:0] element_in_i = '0;
  logic                 out_strobe_o;
  logic signed [DW-1:0] element_out_o;
  logic                 last_element_o;
  logic                 singular_o;
  logic                 saturated_o;

  logic signed [DW-1:0] mat_store [9];
  int                   load_idx = 0;
  inv_elem_t            inverse_q [$];
  int                   errors = 0;

  matrix_inverse_3x3_unit u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .element_in_i  (element_in_i),
    .out_strobe_o  (out_strobe_o),
    .element_out_o (element_out_o),
    .last_element_o(last_element_o),
    .singular_o    (singular_o),
    .saturated_o   (saturated_o)
  );

  always #6 clk_i = ~clk_i;

  function automatic logic signed [127:0] cofactor(int i, int j);
    logic signed [127:0] a, b, c, d;
    a = mat_store[((j + 1) % 3) * 3 + (i + 1) % 3];
    b = mat_store[((j + 2) % 3) * 3 + (i + 2) % 3];
    c = mat_store[((j + 1) % 3) * 3 + (i + 2) % 3];
    d = mat_store[((j + 2) % 3) * 3 + (i + 1) % 3];
    return a * b - c * d;
  endfunction

  task automatic predict_inverse();
    logic signed [127:0] adj [9];
    logic signed [127:0] det, e;
    logic [191:0]        num, den, quo, rem, lim;
    logic                neg;
    inv_elem_t           r;
    for (int k = 0; k < 9; k++) adj[k] = cofactor(k / 3, k % 3);
    det = '0;
    for (int j = 0; j < 3; j++) begin
      e = mat_store[j];
      det = det + e * adj[j * 3];
    end
    for (int k = 0; k < 9; k++) begin
      r.last = (k == 8);
      r.sing = (det == 0);
      r.sat  = 1'b0;
      r.elem = '0;
      if (det != 0) begin
        num = 192'(adj[k] < 0 ? -adj[k] : adj[k]) << (2 * FB);
        den = 192'(det < 0 ? -det : det);
        quo = num / den;
        rem = num % den;
        if ((rem << 1) >= den) quo = quo + 1;
        neg = ((adj[k] < 0) != (det < 0)) && (quo != 0);
        lim = neg ? (192'(1) << (DW - 1)) : ((192'(1) << (DW - 1)) - 1);
        if (quo > lim) begin
          quo = lim;
          r.sat = 1'b1;
        end
        r.elem = neg ? -DW'(quo) : DW'(quo);
      end
      inverse_q.push_back(r);
    end
  endtask

  task automatic send_element(logic signed [DW-1:0] v);
    int gap;
    gap = $urandom_range(0, 5);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start        <= 1'b1;
    element_in_i <= v;
    do @(posedge clk_i); while (busy);
    mat_store[load_idx] = v;
    load_idx++;
    if (load_idx == 9) begin
      load_idx = 0;
      predict_inverse();
    end
  endtask

  task automatic send_matrix(logic signed [DW-1:0] m [9]);
    for (int k = 0; k < 9; k++) send_element(m[k]);
  endtask

  always @(posedge clk_i) begin
    inv_elem_t x;
    if (rst_ni && out_strobe_o) begin
      if (inverse_q.size() == 0) begin
        $error("unexpected result element_out=%0d", element_out_o);
        errors++;
      end else begin
        x = inverse_q.pop_front();
        if (element_out_o !== x.elem) begin
          $error("element_out exp %0d got %0d", x.elem, element_out_o);
          errors++;
        end
        if (last_element_o !== x.last) begin
          $error("last_element exp %0d got %0d", x.last, last_element_o);
          errors++;
        end
        if (singular_o !== x.sing) begin
          $error("singular exp %0d got %0d", x.sing, singular_o);
          errors++;
        end
        if (saturated_o !== x.sat) begin
          $error("saturated exp %0d got %0d", x.sat, saturated_o);
          errors++;
        end
      end
    end
  end

  localparam logic signed [DW-1:0] ONE  = 1 << FB;
  localparam logic signed [DW-1:0] VMAX = {1'b0, {(DW - 1){1'b1}}};
  localparam logic signed [DW-1:0] VMIN = {1'b1, {(DW - 1){1'b0}}};

  task automatic test_saturation();
    logic signed [DW-1:0] m [9];
    m = '{32'sd1, 0, 0, 0, -ONE, 0, 0, 0, VMAX};
    send_matrix(m);
  endtask

  task automatic test_singular();
    logic signed [DW-1:0] m [9];
    m = '{0, 0, 0, 0, 0, 0, 0, 0, 0};
    send_matrix(m);
  endtask

  task automatic test_extremes();
    logic signed [DW-1:0] m [9];
    m = '{VMAX, 0, VMIN, 0, VMIN, 0, VMIN, 0, VMAX - 1};
    send_matrix(m);
  endtask

  task automatic test_random();
    logic signed [DW-1:0] m [9];
    for (int n = 0; n < 10; n++) begin
      for (int k = 0; k < 9; k++) begin
        if ($urandom_range(0, 2) == 0) m[k] = $urandom;
        else m[k] = $signed($urandom_range(0, 8 << FB)) - (4 << FB);
      end
      if ($urandom_range(0, 5) == 0)
        for (int k = 0; k < 3; k++) m[6 + k] = m[k];
      send_matrix(m);
    end
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_saturation();
    test_singular();
    test_extremes();
    test_random();
    start <= 1'b0;
    while (inverse_q.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    if (errors == 0 && inverse_q.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #3000000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
